FILE: src/lskth_pkg.sv
// shared types and constants for the per-row local scale block
// no dependencies
`timescale 1ns / 1ps

package lskth_pkg;

   localparam int MAX_RANK  = 64;
   localparam int MAX_NODES = 4096;

   localparam int DIST_W = 32;
   localparam int RANK_W = $clog2(MAX_RANK + 1);
   localparam int SEL_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int ROW_W  = 12;

   // configuration register indexes
   typedef enum logic [0:0] {
      REG_NEIGHBOR_RANK = 1'b0,
      REG_SELECT_SORT   = 1'b1
   } reg_index_type;

   localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(8);

   // what one cell hands to the next one up the chain
   typedef struct packed {
      logic              keep;
      logic [DIST_W-1:0] value;
   } link_type;

   // index-mode capture as seen at the current beat
   typedef struct packed {
      logic              found;
      logic [DIST_W-1:0] distance;
   } pick_type;

endpackage

FILE: src/local_scale_kth_smallest.sv
// top level: per-row local scale from a stream of row distances
// depends on lskth_pkg, lskth_cell, lskth_pick
`timescale 1ns / 1ps

// channel | direction | beat carries
// req     | in        | distance, last_in_row
// rsp     | out       | row_index, scale, valid_res (one beat per row)
// csr     | in        | index, wdata (neighbor_rank, select_by_sorting)
//
// one distance beat per cycle; the chain of compare cells inserts each
// distance as the beat is taken, so rows stream back to back
// the row result appears in the rsp register in the cycle after the last beat
// req stalls only while a finished result sits unaccepted in that register
// csr is always ready; reset is synchronous and needs no clearing pass

module local_scale_kth_smallest (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lskth_pkg::DIST_W-1:0] req_distance,
   input  logic                         req_last_in_row,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lskth_pkg::ROW_W-1:0]  rsp_row_index,
   output logic [lskth_pkg::DIST_W-1:0] rsp_scale,
   output logic                         rsp_valid_res,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  lskth_pkg::reg_index_type     csr_index,
   input  logic [lskth_pkg::RANK_W-1:0] csr_wdata
);
   import lskth_pkg::*;

   // configuration
   logic [RANK_W-1:0] rank_ff;
   logic              sort_ff;
   logic [RANK_W-1:0] k_eff;

   // row bookkeeping
   logic [RANK_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff;
   logic [RANK_W-1:0] n_cur;
   logic [RANK_W-1:0] n_new;
   logic [SEL_W-1:0]  sel;

   // result register
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [DIST_W-1:0] rsp_scale_ff;
   logic              rsp_res_ff;

   logic              take;
   link_type          head;
   link_type          cell_link  [MAX_RANK];
   logic [DIST_W-1:0] cell_next  [MAX_RANK];
   pick_type          pick;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_RESET;
         sort_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_NEIGHBOR_RANK: rank_ff <= csr_wdata;
            REG_SELECT_SORT:   sort_ff <= csr_wdata[0];
            default:           ;
         endcase
      end
   end

   // clamp k into 1..MAX_RANK
   always_comb begin
      k_eff = rank_ff;
      if (rank_ff == '0) begin
         k_eff = RANK_W'(1);
      end else if (rank_ff > RANK_W'(MAX_RANK)) begin
         k_eff = RANK_W'(MAX_RANK);
      end
   end

   // a beat goes in whenever the result slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   // list held so far, cut to k (a lowered rank trims the tail here)
   assign n_cur = (cnt_ff > k_eff) ? k_eff : cnt_ff;
   assign n_new = (n_cur < k_eff) ? n_cur + RANK_W'(1) : n_cur;
   assign sel   = SEL_W'(n_new - RANK_W'(1));

   assign cnt_in = req_last_in_row ? '0 : n_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         row_ff <= '0;
      end else if (take) begin
         cnt_ff <= cnt_in;
         if (req_last_in_row) begin
            row_ff <= row_ff + ROW_W'(1);
         end
      end
   end

   // the slot below cell 0 always "keeps", so cell 0 takes the new distance
   assign head.keep  = 1'b1;
   assign head.value = '0;

   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      logic occ;
      assign occ = n_cur > RANK_W'(i);
      if (i == 0) begin : g_first
         lskth_cell u_cell (
            .clock    (clock),
            .en       (take),
            .d        (req_distance),
            .occ      (occ),
            .prev     (head),
            .link     (cell_link[i]),
            .value_in (cell_next[i])
         );
      end else begin : g_rest
         lskth_cell u_cell (
            .clock    (clock),
            .en       (take),
            .d        (req_distance),
            .occ      (occ),
            .prev     (cell_link[i-1]),
            .link     (cell_link[i]),
            .value_in (cell_next[i])
         );
      end
   end

   lskth_pick u_pick (
      .clock (clock),
      .reset (reset),
      .en    (take),
      .last  (req_last_in_row),
      .d     (req_distance),
      .row   (row_ff),
      .rank  (k_eff),
      .res   (pick)
   );

   // result capture on the last beat of a row
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_last_in_row) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_last_in_row) begin
         rsp_row_ff <= row_ff;
         if (sort_ff) begin
            // last live slot: k-th smallest, or the row maximum if short
            rsp_scale_ff <= cell_next[sel];
            rsp_res_ff   <= 1'b1;
         end else begin
            rsp_scale_ff <= pick.distance;
            rsp_res_ff   <= pick.found;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_scale     = rsp_scale_ff;
   assign rsp_valid_res = rsp_res_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RANK_W'(MAX_RANK))
      else $error("kept count above list depth");

   a_row_result: assert property (@(posedge clock) disable iff (reset)
      take && req_last_in_row |=> rsp_valid_ff)
      else $error("row end without result");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      take && req_last_in_row |=> row_ff == $past(row_ff) + ROW_W'(1))
      else $error("row counter did not advance");

   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      take && req_last_in_row |=> cnt_ff == '0)
      else $error("list not emptied at row end");
`endif

endmodule

FILE: src/lskth_cell.sv
// one slot of the sorted insertion chain
// depends on lskth_pkg
`timescale 1ns / 1ps

module lskth_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [lskth_pkg::DIST_W-1:0] d,
   input  logic                       occ,
   input  lskth_pkg::link_type        prev,
   output lskth_pkg::link_type        link,
   output logic [lskth_pkg::DIST_W-1:0] value_in
);
   import lskth_pkg::*;

   logic [DIST_W-1:0] value_ff;

   // equal values stay ahead of the new one
   assign link.keep  = occ && (value_ff <= d);
   assign link.value = value_ff;

   assign value_in = link.keep ? value_ff : (prev.keep ? d : prev.value);

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
      end
   end

endmodule

FILE: src/lskth_pick.sv
// index-mode column capture for the current row
// depends on lskth_pkg
`timescale 1ns / 1ps

module lskth_pick (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         last,
   input  logic [lskth_pkg::DIST_W-1:0] d,
   input  logic [lskth_pkg::ROW_W-1:0]  row,
   input  logic [lskth_pkg::RANK_W-1:0] rank,
   output lskth_pkg::pick_type          res
);
   import lskth_pkg::*;

   logic [NODE_W-1:0] col_ff, col_in;
   logic              found_ff, found_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [NODE_W-1:0] target;
   logic              hit;

   // column k for early rows, column k-1 afterwards
   assign target = (NODE_W'(row) < NODE_W'(rank)) ? NODE_W'(rank)
                                                  : NODE_W'(rank) - NODE_W'(1);
   assign hit    = !found_ff && (col_ff == target);

   assign res.found    = found_ff || hit;
   assign res.distance = found_ff ? dist_ff : (hit ? d : '0);

   always_comb begin
      col_in   = col_ff + NODE_W'(1);
      found_in = res.found;
      dist_in  = res.distance;
      if (last) begin
         col_in   = '0;
         found_in = 1'b0;
         dist_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         found_ff <= 1'b0;
         dist_ff  <= '0;
      end else if (en) begin
         col_ff   <= col_in;
         found_ff <= found_in;
         dist_ff  <= dist_in;
      end
   end

endmodule
